// ----- hdl/asaf_pkg.sv -----
// Shared types and constants for the add/subtract ALU with flags.
`default_nettype none

package asaf_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CMD_W   = 4;
    localparam int unsigned SIGN_IX = 31;

    // Input beat: command, first operand, second operand, set flags (69 bits, padded to 72)
    localparam int unsigned S_TDATA_W = 72;
    // Output beat: result, writes, Z, N, C, V (37 bits, padded to 40)
    localparam int unsigned M_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 4'd0,
        CMD_ADC  = 4'd1,
        CMD_ADD1 = 4'd2,
        CMD_ADD2 = 4'd3,
        CMD_ADD3 = 4'd4,
        CMD_SUB  = 4'd5,
        CMD_SBC  = 4'd6,
        CMD_SUB1 = 4'd7,
        CMD_SUB2 = 4'd8,
        CMD_SUB3 = 4'd9,
        CMD_RSUB = 4'd10,
        CMD_CMP  = 4'd11
    } command_t;

    // Status flags, Z in the top bit down to V
    typedef struct packed {
        logic z;
        logic n;
        logic c;
        logic v;
    } flags_t;

    // One item as held in the input register
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] first_operand;
        logic [DATA_W-1:0] second_operand;
        logic              set_flags;
    } item_t;

    // One result as held in the output register
    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              writes_result;
        flags_t            flags;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/asaf_exec.sv -----
// Combinational add/subtract datapath with Z/N/C/V flag generation.
`default_nettype none

module asaf_exec
(
    input  wire asaf_pkg::item_t   item,
    input  wire asaf_pkg::flags_t  flags_cur,
    output asaf_pkg::result_t      res,
    output asaf_pkg::flags_t       flags_next
);

    logic [asaf_pkg::DATA_W-1:0] op_a;
    logic [asaf_pkg::DATA_W-1:0] op_b;
    logic [asaf_pkg::DATA_W-1:0] addend;
    logic [asaf_pkg::DATA_W-1:0] sum;
    logic                        do_sub;
    logic                        use_carry;
    logic                        known;
    logic                        writes;
    logic                        update;
    logic                        cin;
    asaf_pkg::flags_t            calc;

    // Decode: pick operands, scaling and add/subtract
    always_comb
    begin
        op_a      = item.first_operand;
        op_b      = item.second_operand;
        do_sub    = 1'b0;
        use_carry = 1'b0;
        known     = 1'b1;
        writes    = 1'b1;
        update    = item.set_flags;
        case (item.command)
            asaf_pkg::CMD_ADD:  ;
            asaf_pkg::CMD_ADC:  use_carry = 1'b1;
            asaf_pkg::CMD_ADD1: op_b = item.second_operand << 1;
            asaf_pkg::CMD_ADD2: op_b = item.second_operand << 2;
            asaf_pkg::CMD_ADD3: op_b = item.second_operand << 3;
            asaf_pkg::CMD_SUB:  do_sub = 1'b1;
            asaf_pkg::CMD_SBC:
            begin
                do_sub    = 1'b1;
                use_carry = 1'b1;
            end
            asaf_pkg::CMD_SUB1:
            begin
                do_sub = 1'b1;
                op_b   = item.second_operand << 1;
            end
            asaf_pkg::CMD_SUB2:
            begin
                do_sub = 1'b1;
                op_b   = item.second_operand << 2;
            end
            asaf_pkg::CMD_SUB3:
            begin
                do_sub = 1'b1;
                op_b   = item.second_operand << 3;
            end
            asaf_pkg::CMD_RSUB:
            begin
                do_sub = 1'b1;
                op_a   = item.second_operand;
                op_b   = item.first_operand;
            end
            asaf_pkg::CMD_CMP:
            begin
                do_sub = 1'b1;
                writes = 1'b0;
                update = 1'b1;
            end
            default:
            begin
                known  = 1'b0;
                writes = 1'b0;
                update = 1'b0;
            end
        endcase
    end

    // One adder: subtract is a + ~b + ~borrow
    always_comb
    begin
        addend = do_sub ? ~op_b : op_b;
        cin    = do_sub ? ~(use_carry & flags_cur.c) : (use_carry & flags_cur.c);
        sum    = op_a + addend + {{(asaf_pkg::DATA_W-1){1'b0}}, cin};
    end

    // C and V from the sign bits of operands and result, Z and N from the result
    always_comb
    begin
        calc.z = (sum == '0);
        calc.n = sum[asaf_pkg::SIGN_IX];
        if (do_sub)
        begin
            calc.c = (~op_a[asaf_pkg::SIGN_IX] & op_b[asaf_pkg::SIGN_IX])
                   | (~op_a[asaf_pkg::SIGN_IX] & sum[asaf_pkg::SIGN_IX])
                   | (sum[asaf_pkg::SIGN_IX] & op_b[asaf_pkg::SIGN_IX]);
            calc.v = (op_a[asaf_pkg::SIGN_IX] ^ sum[asaf_pkg::SIGN_IX])
                   & (op_a[asaf_pkg::SIGN_IX] ^ op_b[asaf_pkg::SIGN_IX]);
        end
        else
        begin
            calc.c = (op_a[asaf_pkg::SIGN_IX] & op_b[asaf_pkg::SIGN_IX])
                   | (op_a[asaf_pkg::SIGN_IX] & ~sum[asaf_pkg::SIGN_IX])
                   | (op_b[asaf_pkg::SIGN_IX] & ~sum[asaf_pkg::SIGN_IX]);
            calc.v = (op_a[asaf_pkg::SIGN_IX] ^ sum[asaf_pkg::SIGN_IX])
                   & ~(op_a[asaf_pkg::SIGN_IX] ^ op_b[asaf_pkg::SIGN_IX]);
        end
    end

    // Unknown commands report zero and leave the flags alone
    always_comb
    begin
        flags_next        = update ? calc : flags_cur;
        res.result_value  = known ? sum : '0;
        res.writes_result = writes;
        res.flags         = flags_next;
    end

endmodule

`default_nettype wire

// ----- hdl/add_sub_alu_with_flags.sv -----
// An accepted beat moves from the input register to the output register, which offers it.
// Throughput: one beat per cycle while the master side does not stall; input register,
// add/subtract logic, output register. The carry used by ADC/SBC comes from the flag register,
// updated as each beat leaves the input register, so back-to-back beats see the flags of the beat before.
// Reset (rst_n low, asynchronous): both stages empty and all flags cleared.
// The master side may stall; the input register refills as the output register drains.
`default_nettype none

module add_sub_alu_with_flags
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [3:0] command, [35:4] first_operand, [67:36] second_operand, [68] set_flags, zero pad
    input  wire  [asaf_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [31:0] result_value, [32] writes_result, [33] zero_flag, [34] negative_flag,
    // [35] carry_flag, [36] overflow_flag, zero pad
    output logic [asaf_pkg::M_TDATA_W-1:0]   m_tdata
);

    asaf_pkg::item_t   item_reg;
    logic              item_vld_reg;
    asaf_pkg::result_t res_reg;
    asaf_pkg::result_t res_next;
    logic              res_vld_reg;
    asaf_pkg::flags_t  flags_reg;
    asaf_pkg::flags_t  flags_next;
    logic              advance;
    asaf_pkg::item_t   s_item;

    // Unpack the slave beat
    always_comb
    begin
        s_item.command        = s_tdata[3:0];
        s_item.first_operand  = s_tdata[35:4];
        s_item.second_operand = s_tdata[67:36];
        s_item.set_flags      = s_tdata[68];
    end

    // Output register can load when empty or being drained
    assign advance  = !res_vld_reg || m_tready;
    assign s_tready = !item_vld_reg || advance;

    asaf_exec u_exec
    (
        .item       (item_reg),
        .flags_cur  (flags_reg),
        .res        (res_next),
        .flags_next (flags_next)
    );

    // Control and flag state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            flags_reg    <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                item_vld_reg <= s_tvalid;
            end
            if (advance)
            begin
                res_vld_reg <= item_vld_reg;
                if (item_vld_reg)
                begin
                    flags_reg <= flags_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= s_item;
        end
        if (advance && item_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    // Pack the master beat
    assign m_tvalid = res_vld_reg;
    assign m_tdata  = {3'b000,
                       res_reg.flags.v,
                       res_reg.flags.c,
                       res_reg.flags.n,
                       res_reg.flags.z,
                       res_reg.writes_result,
                       res_reg.result_value};

    // Flags move only when a beat passes from input to output register
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && item_vld_reg) |=> $stable(flags_reg))
        else $error("flag register changed without a beat moving");

    // A waiting result always carries the flags now stored
    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> (res_reg.flags == flags_reg))
        else $error("output flags differ from stored flags");

    // An empty output stage never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_vld_reg |-> s_tready)
        else $error("input stalled with empty output register");

    // Compare yields no write
    a_no_write_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && (item_reg.command == asaf_pkg::CMD_CMP)) |-> !res_next.writes_result)
        else $error("compare flagged as writing a result");

endmodule

`default_nettype wire

// ----- bench/add_sub_alu_with_flags_tb.sv -----
// Self-checking testbench for the add/subtract ALU with its kept Z, N, C, V flag register.
`timescale 1ns / 100ps

module add_sub_alu_with_flags_tb;

    localparam int unsigned IDLE_PCT      = 37;
    localparam int unsigned RANDOM_OPS    = 1650;
    localparam int unsigned CALM_FIRST    = 600;
    localparam int unsigned CALM_LAST     = 900;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned MAX_PRINTED   = 50;
    localparam logic [asaf_pkg::CMD_W-1:0] CMD_UNUSED_LO = 4'd12;
    localparam logic [asaf_pkg::CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

    // Tracks the flag register and holds the outcomes still owed by the block
    class nzcv_scoreboard;
        asaf_pkg::flags_t  kept_flags;
        asaf_pkg::result_t awaited_outcomes[$];
        int                mismatch_count;
        int                result_index;

        function new();
            kept_flags     = '0;
            mismatch_count = 0;
            result_index   = 0;
        endfunction

        // Work out the outcome of one accepted operation and queue it
        function void note_operation(asaf_pkg::item_t op);
            logic [asaf_pkg::DATA_W:0]   wide;
            logic [asaf_pkg::DATA_W-1:0] lhs;
            logic [asaf_pkg::DATA_W-1:0] rhs;
            logic [asaf_pkg::DATA_W-1:0] sum;
            logic                        carry_in;
            logic                        subtract;
            logic                        known;
            logic                        update;
            asaf_pkg::flags_t            next_flags;
            asaf_pkg::result_t           outcome;

            lhs        = op.first_operand;
            rhs        = op.second_operand;
            carry_in   = 1'b0;
            subtract   = 1'b0;
            known      = 1'b1;
            update     = op.set_flags;
            next_flags = kept_flags;
            sum        = '0;
            outcome.writes_result = 1'b1;

            case (op.command)
                asaf_pkg::CMD_ADD:  ;
                asaf_pkg::CMD_ADC:  carry_in = kept_flags.c;
                asaf_pkg::CMD_ADD1: rhs = op.second_operand << 1;
                asaf_pkg::CMD_ADD2: rhs = op.second_operand << 2;
                asaf_pkg::CMD_ADD3: rhs = op.second_operand << 3;
                asaf_pkg::CMD_SUB:  subtract = 1'b1;
                asaf_pkg::CMD_SBC:
                begin
                    subtract = 1'b1;
                    carry_in = kept_flags.c;
                end
                asaf_pkg::CMD_SUB1:
                begin
                    subtract = 1'b1;
                    rhs      = op.second_operand << 1;
                end
                asaf_pkg::CMD_SUB2:
                begin
                    subtract = 1'b1;
                    rhs      = op.second_operand << 2;
                end
                asaf_pkg::CMD_SUB3:
                begin
                    subtract = 1'b1;
                    rhs      = op.second_operand << 3;
                end
                asaf_pkg::CMD_RSUB:
                begin
                    subtract = 1'b1;
                    lhs      = op.second_operand;
                    rhs      = op.first_operand;
                end
                asaf_pkg::CMD_CMP:
                begin
                    subtract              = 1'b1;
                    update                = 1'b1;
                    outcome.writes_result = 1'b0;
                end
                default:
                begin
                    known                 = 1'b0;
                    update                = 1'b0;
                    outcome.writes_result = 1'b0;
                end
            endcase

            // 33-bit arithmetic: bit 32 is carry out for add, borrow out for subtract
            if (known)
            begin
                if (subtract)
                begin
                    wide         = {1'b0, lhs} - {1'b0, rhs} - carry_in;
                    sum          = wide[asaf_pkg::DATA_W-1:0];
                    next_flags.v = (lhs[asaf_pkg::SIGN_IX] != rhs[asaf_pkg::SIGN_IX])
                                && (sum[asaf_pkg::SIGN_IX] != lhs[asaf_pkg::SIGN_IX]);
                end
                else
                begin
                    wide         = {1'b0, lhs} + {1'b0, rhs} + carry_in;
                    sum          = wide[asaf_pkg::DATA_W-1:0];
                    next_flags.v = (lhs[asaf_pkg::SIGN_IX] == rhs[asaf_pkg::SIGN_IX])
                                && (sum[asaf_pkg::SIGN_IX] != lhs[asaf_pkg::SIGN_IX]);
                end
                next_flags.c = wide[asaf_pkg::DATA_W];
                next_flags.z = (sum == '0);
                next_flags.n = sum[asaf_pkg::SIGN_IX];
            end

            if (update)
                kept_flags = next_flags;

            outcome.result_value = sum;
            outcome.flags        = kept_flags;
            awaited_outcomes.push_back(outcome);
        endfunction

        task report(string msg);
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTED)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        task compare_field(string field, logic [asaf_pkg::DATA_W-1:0] want,
                           logic [asaf_pkg::DATA_W-1:0] seen);
            if (want !== seen)
                report($sformatf("beat %0d %s expected %h got %h", result_index, field, want, seen));
        endtask

        task compare_bit(string field, logic want, logic seen);
            if (want !== seen)
                report($sformatf("beat %0d %s expected %b got %b", result_index, field, want, seen));
        endtask

        // Compare one output beat with the oldest queued outcome
        task check_result(asaf_pkg::result_t seen);
            asaf_pkg::result_t want;

            if (awaited_outcomes.size() == 0)
            begin
                report($sformatf("beat %0d arrived with nothing awaited", result_index));
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                compare_field("result_value",  want.result_value,  seen.result_value);
                compare_bit("writes_result",   want.writes_result, seen.writes_result);
                compare_bit("zero_flag",       want.flags.z,       seen.flags.z);
                compare_bit("negative_flag",   want.flags.n,       seen.flags.n);
                compare_bit("carry_flag",      want.flags.c,       seen.flags.c);
                compare_bit("overflow_flag",   want.flags.v,       seen.flags.v);
            end
            result_index++;
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [asaf_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [asaf_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           calm;

    nzcv_scoreboard sb;

    add_sub_alu_with_flags dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output side: random back-pressure, none during the calm stretch
    always @(posedge clk)
        m_tready <= rst_n && (calm || ($urandom_range(0, 99) >= IDLE_PCT));

    // Watch both handshakes; inputs are noted before outputs are checked
    always @(posedge clk)
    begin
        asaf_pkg::item_t   op;
        asaf_pkg::result_t seen;

        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                op.command        = s_tdata[3:0];
                op.first_operand  = s_tdata[35:4];
                op.second_operand = s_tdata[67:36];
                op.set_flags      = s_tdata[68];
                sb.note_operation(op);
            end
            if (m_tvalid && m_tready)
            begin
                seen.result_value  = m_tdata[31:0];
                seen.writes_result = m_tdata[32];
                seen.flags.z       = m_tdata[33];
                seen.flags.n       = m_tdata[34];
                seen.flags.c       = m_tdata[35];
                seen.flags.v       = m_tdata[36];
                sb.check_result(seen);
            end
        end
    end

    // Offer one beat after random idle cycles and hold it until accepted
    task automatic send_op(logic [asaf_pkg::CMD_W-1:0] cmd, logic [asaf_pkg::DATA_W-1:0] a,
                           logic [asaf_pkg::DATA_W-1:0] b, logic sf);
        while (!calm && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sf, b, a, cmd};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Operands lean toward the sign and carry boundaries
    function automatic logic [asaf_pkg::DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return $urandom_range(0, 15);
            5:       return 32'hE000_0000 | $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [asaf_pkg::CMD_W-1:0]  cmd;
        logic [asaf_pkg::DATA_W-1:0] a;
        logic [asaf_pkg::DATA_W-1:0] b;

        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        calm     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: carries, borrows, overflows, lost shift bits, CMP, unknown commands
        send_op(asaf_pkg::CMD_ADD,  32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
        send_op(asaf_pkg::CMD_ADC,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
        send_op(asaf_pkg::CMD_ADD,  32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
        send_op(asaf_pkg::CMD_ADD1, 32'h0000_0000, 32'hC000_0001, 1'b1);
        send_op(asaf_pkg::CMD_ADD2, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
        send_op(asaf_pkg::CMD_ADD3, 32'hFFFF_FFFF, 32'h2000_0000, 1'b1);
        send_op(asaf_pkg::CMD_ADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_op(asaf_pkg::CMD_ADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_op(asaf_pkg::CMD_ADC,  32'h0000_0000, 32'h0000_0000, 1'b0);
        send_op(asaf_pkg::CMD_SUB,  32'h0000_0000, 32'h0000_0001, 1'b1);
        send_op(asaf_pkg::CMD_SBC,  32'h0000_0000, 32'h0000_0000, 1'b1);
        send_op(asaf_pkg::CMD_SBC,  32'h8000_0000, 32'h0000_0000, 1'b1);
        send_op(asaf_pkg::CMD_SUB,  32'h8000_0000, 32'h0000_0001, 1'b1);
        send_op(asaf_pkg::CMD_SUB1, 32'h0000_0000, 32'h8000_0000, 1'b1);
        send_op(asaf_pkg::CMD_SUB2, 32'h0000_0004, 32'h0000_0001, 1'b1);
        send_op(asaf_pkg::CMD_SUB3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_op(asaf_pkg::CMD_RSUB, 32'h0000_0005, 32'h0000_0003, 1'b1);
        send_op(asaf_pkg::CMD_RSUB, 32'h0000_0001, 32'h8000_0000, 1'b0);
        send_op(asaf_pkg::CMD_CMP,  32'h0000_002A, 32'h0000_002A, 1'b0);
        send_op(asaf_pkg::CMD_CMP,  32'h8000_0000, 32'h0000_0001, 1'b1);
        send_op(CMD_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_op(CMD_UNUSED_HI, 32'h1234_5678, 32'h8765_4321, 1'b0);
        send_op(asaf_pkg::CMD_ADC,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1);

        // Random: mostly real commands, a few unknown ones, a stretch with no idling
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            calm <= (i >= CALM_FIRST) && (i < CALM_LAST);
            if ($urandom_range(0, 99) < 5)
                cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            else
                cmd = 4'($urandom_range(asaf_pkg::CMD_ADD, asaf_pkg::CMD_CMP));
            a = pick_operand();
            b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
            send_op(cmd, a, b, 1'($urandom_range(0, 1)));
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        // Drain, then give the pipeline time to show any stray beat
        do
            @(posedge clk);
        while (sb.awaited_outcomes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.awaited_outcomes.size() == 0)
            $display("[add_sub_alu_with_flags] OK");
        else
            $display("[add_sub_alu_with_flags] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("[add_sub_alu_with_flags] ERROR");
        $finish;
    end

endmodule
